// ===== rtl/core/trie_string_counter_unit_macros.svh =====
// assertion macros for the trie string counter unit
// no dependencies; taken in by `include where assertions are written
`ifndef TRIE_STRING_COUNTER_UNIT_MACROS_SVH
`define TRIE_STRING_COUNTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define TSCU_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("tscu assertion failed");

// next-cycle implication, checked out of reset
`define TSCU_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("tscu assertion failed");

`else

`define TSCU_ASSERT_NOW(label, clk, rst, cond, cons)
`define TSCU_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// ===== rtl/core/tscu_pkg.sv =====
// shared types and constants for the trie string counter unit
// no dependencies
`timescale 1ns / 1ps

package tscu_pkg;

   localparam int NODES_DEF      = 1024;
   localparam int ALPHABET_DEF   = 26;
   localparam int COUNT_BITS_DEF = 20;

   localparam int LETTER_W    = 5;
   localparam int COUNT_OUT_W = 20;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_COUNT
   } state_type;

   // read and write strobes of one memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

   // status of the clearing pass after reset
   typedef struct packed {
      logic busy;
      logic count_wr;
   } clr_stat_type;

endpackage

// ===== rtl/core/tscu_ram.sv =====
// generic single-clock ram, one write and one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module tscu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tscu_clear.sv =====
// clearing sweep over the child table and the end counts after reset
// depends on tscu_pkg
`timescale 1ns / 1ps

module tscu_clear #(
   parameter int NODES    = tscu_pkg::NODES_DEF,
   parameter int ALPHABET = tscu_pkg::ALPHABET_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   output tscu_pkg::clr_stat_type                stat,
   output logic [$clog2(NODES*ALPHABET)-1:0]     index
);

   localparam int TOTAL  = NODES * ALPHABET;
   localparam int SLOT_W = $clog2(TOTAL);

   logic              busy_ff, busy_in;
   logic [SLOT_W-1:0] index_ff, index_in;

   always_comb begin
      busy_in  = busy_ff;
      index_in = index_ff;
      if (busy_ff) begin
         index_in = index_ff + SLOT_W'(1);
         if (index_ff == SLOT_W'(TOTAL - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         index_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
   end

   assign stat.busy     = busy_ff;
   assign stat.count_wr = busy_ff && (32'(index_ff) < NODES);
   assign index         = index_ff;

endmodule

// ===== rtl/core/tscu_ctrl.sv =====
// letter sequencer: cursor walk, node allocation, count update, result register
// depends on tscu_pkg
`timescale 1ns / 1ps

module tscu_ctrl #(
   parameter int NODES      = tscu_pkg::NODES_DEF,
   parameter int ALPHABET   = tscu_pkg::ALPHABET_DEF,
   parameter int COUNT_BITS = tscu_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear_busy,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tscu_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tscu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output tscu_pkg::mem_cmd_type               child_cmd,
   output logic [$clog2(NODES*ALPHABET)-1:0]   child_rd_addr,
   output logic [$clog2(NODES*ALPHABET)-1:0]   child_wr_addr,
   output logic [$clog2(NODES)-1:0]            child_wr_data,
   input  logic [$clog2(NODES)-1:0]            child_rd_data,
   output tscu_pkg::mem_cmd_type               count_cmd,
   output logic [$clog2(NODES)-1:0]            count_rd_addr,
   output logic [$clog2(NODES)-1:0]            count_wr_addr,
   output logic [COUNT_BITS-1:0]               count_wr_data,
   input  logic [COUNT_BITS-1:0]               count_rd_data
);

   localparam int NODE_W = $clog2(NODES);
   localparam int SLOT_W = $clog2(NODES * ALPHABET);
   localparam int OUT_W  = tscu_pkg::COUNT_OUT_W;

   tscu_pkg::state_type state_ff, state_in;

   logic              op_ff, op_in;
   logic              letter_ok_ff, letter_ok_in;
   logic              last_ff, last_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [NODE_W-1:0] next_free_ff, next_free_in;
   logic              miss_ff, miss_in;
   logic              drop_ff, drop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_status_ff, rsp_status_in;

   logic                      accept;
   logic                      rsp_free;
   logic                      halted;
   logic [tscu_pkg::LETTER_W-1:0] letter;
   logic                      letter_ok_now;
   logic [SLOT_W-1:0]         slot_now;
   logic [COUNT_BITS-1:0]     count_next;
   logic                      alloc;

   assign letter        = req_tdata[tscu_pkg::LETTER_W-1:0];
   assign letter_ok_now = 32'(letter) < ALPHABET;
   assign slot_now      = letter_ok_now
                          ? SLOT_W'(cursor_ff) * SLOT_W'(ALPHABET) + SLOT_W'(letter)
                          : '0;
   assign accept        = req_tvalid && req_tready;
   assign rsp_free      = !rsp_valid_ff || rsp_tready;
   assign halted        = miss_ff || drop_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tscu_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tscu_pkg::ST_LOOK;
            end
         end
         tscu_pkg::ST_LOOK: begin
            state_in = last_ff ? tscu_pkg::ST_COUNT : tscu_pkg::ST_IDLE;
         end
         tscu_pkg::ST_COUNT: begin
            if (rsp_free) begin
               state_in = tscu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tscu_pkg::ST_IDLE;
         end
      endcase
   end

   // handshake and memory strobes
   always_comb begin
      req_tready      = 1'b0;
      child_cmd.rd_en = 1'b0;
      child_cmd.wr_en = 1'b0;
      count_cmd.rd_en = 1'b0;
      count_cmd.wr_en = 1'b0;
      unique case (state_ff)
         tscu_pkg::ST_IDLE: begin
            req_tready      = !clear_busy;
            child_cmd.rd_en = accept;
         end
         tscu_pkg::ST_LOOK: begin
            child_cmd.wr_en = alloc;
            count_cmd.rd_en = last_ff;
         end
         tscu_pkg::ST_COUNT: begin
            count_cmd.wr_en = rsp_free && (op_ff == tscu_pkg::OP_INSERT) && !halted;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // a missing child on an insert takes the next free node unless the pool is full
   assign alloc = (state_ff == tscu_pkg::ST_LOOK) && !halted && letter_ok_ff
                  && (child_rd_data == '0) && (op_ff == tscu_pkg::OP_INSERT)
                  && (next_free_ff != NODE_W'(NODES - 1));

   assign count_next = (count_rd_data == '1) ? count_rd_data
                                             : count_rd_data + COUNT_BITS'(1);

   // datapath
   always_comb begin
      op_in         = op_ff;
      letter_ok_in  = letter_ok_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      cursor_in     = cursor_ff;
      next_free_in  = next_free_ff;
      miss_in       = miss_ff;
      drop_in       = drop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         tscu_pkg::ST_IDLE: begin
            if (accept) begin
               op_in        = req_tuser;
               letter_ok_in = letter_ok_now;
               last_in      = req_tlast;
               slot_in      = slot_now;
            end
         end
         tscu_pkg::ST_LOOK: begin
            if (!halted) begin
               if (!letter_ok_ff) begin
                  miss_in = (op_ff == tscu_pkg::OP_QUERY);
                  drop_in = (op_ff == tscu_pkg::OP_INSERT);
               end else if (child_rd_data == '0) begin
                  if (op_ff == tscu_pkg::OP_QUERY) begin
                     miss_in = 1'b1;
                  end else if (alloc) begin
                     next_free_in = next_free_ff + NODE_W'(1);
                     cursor_in    = next_free_ff + NODE_W'(1);
                  end else begin
                     drop_in = 1'b1;
                  end
               end else begin
                  cursor_in = child_rd_data;
               end
            end
         end
         tscu_pkg::ST_COUNT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = tscu_pkg::STATUS_OK;
               if (halted) begin
                  rsp_count_in = '0;
                  if (op_ff == tscu_pkg::OP_INSERT && drop_ff) begin
                     rsp_status_in = tscu_pkg::STATUS_DROPPED;
                  end
               end else if (op_ff == tscu_pkg::OP_QUERY) begin
                  rsp_count_in = OUT_W'(count_rd_data);
               end else begin
                  rsp_count_in = OUT_W'(count_next);
               end
               cursor_in = '0;
               miss_in   = 1'b0;
               drop_in   = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tscu_pkg::ST_IDLE;
         cursor_ff    <= '0;
         next_free_ff <= '0;
         miss_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         next_free_ff <= next_free_in;
         miss_ff      <= miss_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      letter_ok_ff  <= letter_ok_in;
      last_ff       <= last_in;
      slot_ff       <= slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign child_rd_addr = slot_now;
   assign child_wr_addr = slot_ff;
   assign child_wr_data = next_free_ff + NODE_W'(1);
   assign count_rd_addr = cursor_in;
   assign count_wr_addr = cursor_ff;
   assign count_wr_data = count_next;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tscu_pkg::RSP_DATA_W - OUT_W){1'b0}}, rsp_count_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/core/trie_string_counter_unit.sv =====
// top level of the trie string counter: sequencer, clearing sweep, two rams
// depends on tscu_pkg, tscu_ram, tscu_clear, tscu_ctrl and the assertion macros
//
//  channel  dir  tdata                      tuser            tlast
//  req_     in   [4:0] letter, zero pad     operation        last letter
//  rsp_     out  [19:0] count, zero pad     status           -
//
// a letter that does not end its string goes through child table read, then update
// the last letter goes through child read, end count read, count write and result
// the registered child table read sets these steps; the result register frees the
// input side, so only a last letter waits while an earlier result is not taken
// after reset a pass clears all NODES*ALPHABET child slots with req_tready low
`timescale 1ns / 1ps
`include "trie_string_counter_unit_macros.svh"

module trie_string_counter_unit #(
   parameter int NODES      = tscu_pkg::NODES_DEF,
   parameter int ALPHABET   = tscu_pkg::ALPHABET_DEF,
   parameter int COUNT_BITS = tscu_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tscu_pkg::REQ_DATA_W-1:0] req_tdata,   // [4:0] letter
   input  logic                            req_tuser,   // [0] operation
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tscu_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [19:0] count
   output logic                            rsp_tuser    // [0] status
);

   localparam int NODE_W = $clog2(NODES);
   localparam int SLOT_W = $clog2(NODES * ALPHABET);

   tscu_pkg::clr_stat_type clr_stat;
   logic [SLOT_W-1:0]      clr_index;

   tscu_pkg::mem_cmd_type  child_cmd;
   logic [SLOT_W-1:0]      child_rd_addr, child_wr_addr, child_ram_wr_addr;
   logic [NODE_W-1:0]      child_wr_data, child_ram_wr_data, child_rd_data;
   logic                   child_ram_wr_en;

   tscu_pkg::mem_cmd_type  count_cmd;
   logic [NODE_W-1:0]      count_rd_addr, count_wr_addr, count_ram_wr_addr;
   logic [COUNT_BITS-1:0]  count_wr_data, count_ram_wr_data, count_rd_data;
   logic                   count_ram_wr_en;

   tscu_clear #(
      .NODES    (NODES),
      .ALPHABET (ALPHABET)
   ) u_clear (
      .clock (clock),
      .reset (reset),
      .stat  (clr_stat),
      .index (clr_index)
   );

   tscu_ctrl #(
      .NODES      (NODES),
      .ALPHABET   (ALPHABET),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .clear_busy    (clr_stat.busy),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .child_cmd     (child_cmd),
      .child_rd_addr (child_rd_addr),
      .child_wr_addr (child_wr_addr),
      .child_wr_data (child_wr_data),
      .child_rd_data (child_rd_data),
      .count_cmd     (count_cmd),
      .count_rd_addr (count_rd_addr),
      .count_wr_addr (count_wr_addr),
      .count_wr_data (count_wr_data),
      .count_rd_data (count_rd_data)
   );

   // the sweep owns the write ports until it is done
   assign child_ram_wr_en   = clr_stat.busy || child_cmd.wr_en;
   assign child_ram_wr_addr = clr_stat.busy ? clr_index : child_wr_addr;
   assign child_ram_wr_data = clr_stat.busy ? '0 : child_wr_data;

   assign count_ram_wr_en   = clr_stat.busy ? clr_stat.count_wr : count_cmd.wr_en;
   assign count_ram_wr_addr = clr_stat.busy ? clr_index[NODE_W-1:0] : count_wr_addr;
   assign count_ram_wr_data = clr_stat.busy ? '0 : count_wr_data;

   tscu_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES * ALPHABET)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_ram_wr_en),
      .wr_addr (child_ram_wr_addr),
      .wr_data (child_ram_wr_data),
      .rd_en   (child_cmd.rd_en),
      .rd_addr (child_rd_addr),
      .rd_data (child_rd_data)
   );

   tscu_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NODES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_ram_wr_en),
      .wr_addr (count_ram_wr_addr),
      .wr_data (count_ram_wr_data),
      .rd_en   (count_cmd.rd_en),
      .rd_addr (count_rd_addr),
      .rd_data (count_rd_data)
   );

   `TSCU_ASSERT_NOW(a_no_accept_while_clearing, clock, reset, clr_stat.busy, !req_tready)
   `TSCU_ASSERT_NOW(a_alloc_never_root, clock, reset,
      child_cmd.wr_en && !clr_stat.busy, child_wr_data != '0)
   `TSCU_ASSERT_NEXT(a_count_write_gives_word, clock, reset,
      count_cmd.wr_en && !clr_stat.busy, rsp_tvalid)
   `TSCU_ASSERT_NOW(a_no_read_write_clash, clock, reset,
      child_cmd.rd_en, !child_cmd.wr_en)

endmodule
